>>> hdl/dqi_pkg.sv
`timescale 1ns / 1ps
// Package for the indexed double-ended queue: transaction payload types,
// operation codes, default sizes and the per-cell control struct.
package dqi_pkg;

   localparam int DEPTH_DEFAULT      = 16;
   localparam int DATA_WIDTH_DEFAULT = 32;

   localparam logic [1:0] KIND_PUSH_FRONT = 2'd0;
   localparam logic [1:0] KIND_PUSH_BACK  = 2'd1;
   localparam logic [1:0] KIND_READ       = 2'd2;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [31:0] value;
      logic [3:0]         position;
   } req_type;

   typedef struct packed {
      logic signed [31:0] read_value;
      logic signed [31:0] front_value;
      logic signed [31:0] back_value;
      logic [4:0]         element_count;
      logic               is_empty;
      logic               range_miss;
      logic               overflow;
   } rsp_type;

   // Broadcast to every cell of the chain for one accepted transaction.
   typedef struct packed {
      logic push_front;   // whole chain shifts one place toward the back
      logic load_back;    // the cell at the current count takes the new word
   } ctrl_type;

endpackage

>>> hdl/double_ended_queue_indexed_unit.sv
`timescale 1ns / 1ps
// Indexed double-ended queue built as a chain of DEPTH cells, cell i holding
// the element at position i; push front shifts the whole chain one place and
// push back loads the cell at the current count. Every transaction (push
// front, push back, read at position) is answered with one registered result
// in the cycle after it is accepted; a new request is accepted whenever the
// result register is empty or being drained, so the block sustains one
// transaction per clock. Results carry front, back, count and flags after
// the operation. Depends on dqi_pkg and dqi_cell.
module double_ended_queue_indexed_unit #(
   parameter int DEPTH      = dqi_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = dqi_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  dqi_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output dqi_pkg::rsp_type rsp_payload
);

   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int CMP_W    = (CNT_W > 4) ? CNT_W : 4;
   localparam int RD_CELLS = (DEPTH < 16) ? DEPTH : 16;

   logic [CNT_W-1:0]      count_ff;
   logic [CNT_W-1:0]      count_in;
   logic [DATA_WIDTH-1:0] back_ff;
   logic [DATA_WIDTH-1:0] back_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   dqi_pkg::rsp_type      rsp_ff;
   dqi_pkg::rsp_type      rsp_in;

   logic                  accept;
   logic                  full;
   logic                  is_push;
   logic                  do_front;
   logic                  do_back;
   logic                  is_read;
   logic                  read_hit;
   logic [DATA_WIDTH-1:0] new_word;
   logic [DATA_WIDTH-1:0] rd_word;
   logic [DATA_WIDTH-1:0] front_word;
   dqi_pkg::ctrl_type     ctrl;
   logic [DATA_WIDTH-1:0] cell_q [DEPTH];

   // Sign-extend (or truncate) a stored word to the 32-bit result width.
   function automatic logic [31:0] widen(input logic [DATA_WIDTH-1:0] w);
      logic [31:0] r;
      for (int b = 0; b < 32; b++) begin
         r[b] = w[(b < DATA_WIDTH) ? b : DATA_WIDTH - 1];
      end
      return r;
   endfunction

   assign accept    = req_valid && req_ready;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign full      = (count_ff == CNT_W'(DEPTH));
   assign is_push   = (req_payload.kind == dqi_pkg::KIND_PUSH_FRONT) ||
                      (req_payload.kind == dqi_pkg::KIND_PUSH_BACK);
   assign do_front  = accept && !full && (req_payload.kind == dqi_pkg::KIND_PUSH_FRONT);
   assign do_back   = accept && !full && (req_payload.kind == dqi_pkg::KIND_PUSH_BACK);
   assign is_read   = (req_payload.kind == dqi_pkg::KIND_READ);
   assign read_hit  = CMP_W'(req_payload.position) < CMP_W'(count_ff);

   assign ctrl.push_front = do_front;
   assign ctrl.load_back  = do_back;

   // Low DATA_WIDTH bits of the input word; zero above bit 31 for wide words.
   always_comb begin
      for (int b = 0; b < DATA_WIDTH; b++) begin
         new_word[b] = (b < 32) ? req_payload.value[(b < 32) ? b : 31] : 1'b0;
      end
   end

   genvar g;
   generate
      for (g = 0; g < DEPTH; g++) begin : g_cell
         dqi_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .CNT_W      (CNT_W),
            .INDEX      (g)
         ) u_cell (
            .clock     (clock),
            .ctrl      (ctrl),
            .count     (count_ff),
            .prev_data ((g == 0) ? new_word : cell_q[(g == 0) ? 0 : g - 1]),
            .new_data  (new_word),
            .data      (cell_q[g])
         );
      end
   endgenerate

   // Only the first sixteen cells are reachable by the 4-bit position.
   always_comb begin
      rd_word = '0;
      for (int i = 0; i < RD_CELLS; i++) begin
         rd_word = rd_word | (cell_q[i] & {DATA_WIDTH{req_payload.position == 4'(i)}});
      end
   end

   always_comb begin
      count_in   = count_ff;
      back_in    = back_ff;
      front_word = cell_q[0];
      if (do_front) begin
         count_in   = count_ff + CNT_W'(1);
         front_word = new_word;
         if (count_ff == '0) begin
            back_in = new_word;
         end
      end else if (do_back) begin
         count_in = count_ff + CNT_W'(1);
         back_in  = new_word;
         if (count_ff == '0) begin
            front_word = new_word;
         end
      end
   end

   always_comb begin
      rsp_in               = rsp_ff;
      rsp_valid_in         = rsp_valid_ff && !rsp_ready;
      if (accept) begin
         rsp_valid_in          = 1'b1;
         rsp_in.read_value     = (is_read && read_hit) ? widen(rd_word) : 32'sd0;
         rsp_in.front_value    = (count_in == '0) ? 32'sd0 : widen(front_word);
         rsp_in.back_value     = (count_in == '0) ? 32'sd0 : widen(back_in);
         rsp_in.element_count  = 5'(count_in);
         rsp_in.is_empty       = (count_in == '0);
         rsp_in.range_miss     = is_read && !read_hit;
         rsp_in.overflow       = is_push && full;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      back_ff <= back_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

>>> hdl/dqi_cell.sv
`timescale 1ns / 1ps
// One storage cell of the deque chain. Holds the element at position INDEX
// and takes its front neighbor's word on a push front. Depends on dqi_pkg.
module dqi_cell #(
   parameter int DATA_WIDTH = dqi_pkg::DATA_WIDTH_DEFAULT,
   parameter int CNT_W      = 5,
   parameter int INDEX      = 0
) (
   input  logic                  clock,
   input  dqi_pkg::ctrl_type     ctrl,
   input  logic [CNT_W-1:0]      count,
   input  logic [DATA_WIDTH-1:0] prev_data,
   input  logic [DATA_WIDTH-1:0] new_data,
   output logic [DATA_WIDTH-1:0] data
);

   logic [DATA_WIDTH-1:0] data_ff;
   logic [DATA_WIDTH-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (ctrl.push_front) begin
         data_in = prev_data;
      end else if (ctrl.load_back && (count == CNT_W'(INDEX))) begin
         data_in = new_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

>>> test/double_ended_queue_indexed_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for double_ended_queue_indexed_unit: push front, push back and
// indexed read, checked field by field against a ring-buffer predictor kept here.
// Depends on dqi_pkg and the unit under test.
module double_ended_queue_indexed_unit_tb;

   localparam int DEPTH = dqi_pkg::DEPTH_DEFAULT;
   // unused code point, block takes no action on it
   localparam logic [1:0] KIND_NOP = 2'd3;

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             req_valid   = 1'b0;
   logic             req_ready;
   dqi_pkg::req_type req_payload = '0;
   logic             rsp_valid;
   logic             rsp_ready   = 1'b0;
   dqi_pkg::rsp_type rsp_payload;

   double_ended_queue_indexed_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always #1 clock = ~clock;

   // predictor state
   logic signed [31:0] ring_words [DEPTH];
   logic [3:0]         ring_head = '0;
   logic [4:0]         ring_fill = '0;

   dqi_pkg::req_type pending_ops [$];
   dqi_pkg::rsp_type expected_rsps [$];
   int      queued_ops     = 0;
   int      accepted_ops   = 0;
   int      checked_rsps   = 0;
   int      mismatches     = 0;
   int      send_idle_pct  = 0;
   int      recv_stall_pct = 0;
   int      reads_hit      = 0;
   int      reads_missed   = 0;
   int      pushes_dropped = 0;
   int      nops_seen      = 0;
   logic    req_taken      = 1'b0;

   function automatic dqi_pkg::rsp_type deque_step(dqi_pkg::req_type op);
      dqi_pkg::rsp_type res;
      logic [3:0]       slot;
      res = '0;
      case (op.kind)
         dqi_pkg::KIND_PUSH_FRONT, dqi_pkg::KIND_PUSH_BACK: begin
            if (ring_fill == DEPTH) begin
               res.overflow = 1'b1;
            end else begin
               if (op.kind == dqi_pkg::KIND_PUSH_FRONT) begin
                  ring_head = ring_head - 4'd1;
                  slot = ring_head;
               end else begin
                  slot = ring_head + ring_fill[3:0];
               end
               ring_words[slot] = op.value;
               ring_fill = ring_fill + 5'd1;
            end
         end
         dqi_pkg::KIND_READ: begin
            if (op.position < ring_fill) begin
               slot = ring_head + op.position;
               res.read_value = ring_words[slot];
            end else begin
               res.range_miss = 1'b1;
            end
         end
         default: ;
      endcase
      if (ring_fill != 0) begin
         res.front_value = ring_words[ring_head];
         // fill of DEPTH wraps to 0 in four bits, so head - 1 is the back
         slot = ring_head + ring_fill[3:0] - 4'd1;
         res.back_value = ring_words[slot];
      end
      res.element_count = ring_fill;
      res.is_empty = (ring_fill == 0);
      return res;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      mismatches++;
      $display("mismatch at result %0d: %s got %h want %h", checked_rsps, what, got, want);
   endtask

   // driver: new transaction only once the previous one was taken
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_payload <= pending_ops.pop_front();
            req_valid   <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // monitor: check the result first, then predict the newly accepted request
   always @(posedge clock) begin
      dqi_pkg::rsp_type want;
      req_taken <= !reset && req_valid && req_ready;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               report_mismatch("unexpected result", '0, '0);
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_payload.read_value !== want.read_value)
                  report_mismatch("read_value", rsp_payload.read_value, want.read_value);
               if (rsp_payload.front_value !== want.front_value)
                  report_mismatch("front_value", rsp_payload.front_value, want.front_value);
               if (rsp_payload.back_value !== want.back_value)
                  report_mismatch("back_value", rsp_payload.back_value, want.back_value);
               if (rsp_payload.element_count !== want.element_count)
                  report_mismatch("element_count", 32'(rsp_payload.element_count),
                                  32'(want.element_count));
               if (rsp_payload.is_empty !== want.is_empty)
                  report_mismatch("is_empty", 32'(rsp_payload.is_empty),
                                  32'(want.is_empty));
               if (rsp_payload.range_miss !== want.range_miss)
                  report_mismatch("range_miss", 32'(rsp_payload.range_miss),
                                  32'(want.range_miss));
               if (rsp_payload.overflow !== want.overflow)
                  report_mismatch("overflow", 32'(rsp_payload.overflow),
                                  32'(want.overflow));
            end
            checked_rsps++;
         end
         if (req_valid && req_ready) begin
            want = deque_step(req_payload);
            expected_rsps.insert(expected_rsps.size(), want);
            accepted_ops++;
            if (req_payload.kind == dqi_pkg::KIND_READ && !want.range_miss) reads_hit++;
            if (want.range_miss) reads_missed++;
            if (want.overflow) pushes_dropped++;
            if (req_payload.kind == KIND_NOP) nops_seen++;
         end
      end
   end

   task automatic add_op(logic [1:0] kind, logic [31:0] value, logic [3:0] position);
      dqi_pkg::req_type op;
      op.kind     = kind;
      op.value    = value;
      op.position = position;
      pending_ops.insert(pending_ops.size(), op);
      queued_ops++;
   endtask

   function automatic logic [31:0] pick_word();
      case ($urandom_range(7))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return '1;
         3: return '0;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [1:0] pick_kind();
      int pick;
      pick = $urandom_range(99);
      if (pick < 55) return dqi_pkg::KIND_READ;
      if (pick < 70) return dqi_pkg::KIND_PUSH_FRONT;
      if (pick < 85) return dqi_pkg::KIND_PUSH_BACK;
      return KIND_NOP;
   endfunction

   // queue random traffic under one idle and stall setting, then hold off until drained
   task automatic run_phase(int idle_pct, int stall_pct, int count);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      repeat (count) add_op(pick_kind(), pick_word(), 4'($urandom_range(15)));
      do @(negedge clock);
      while (accepted_ops != queued_ops || expected_rsps.size() != 0);
   endtask

   initial begin
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // empty queue: reads miss, front and back read as zero
      add_op(dqi_pkg::KIND_READ, '0, 4'd0);
      add_op(KIND_NOP, 32'h1234_5678, 4'd7);
      add_op(dqi_pkg::KIND_PUSH_BACK, 32'h7fff_ffff, 4'd0);
      add_op(dqi_pkg::KIND_PUSH_FRONT, 32'h8000_0000, 4'd0);   // head wraps below zero
      add_op(dqi_pkg::KIND_READ, '0, 4'd0);
      add_op(dqi_pkg::KIND_READ, '0, 4'd1);
      add_op(dqi_pkg::KIND_READ, '0, 4'd2);
      add_op(dqi_pkg::KIND_READ, '1, 4'd15);
      add_op(dqi_pkg::KIND_PUSH_FRONT, '1, 4'd15);
      add_op(dqi_pkg::KIND_PUSH_BACK, '0, 4'd0);
      add_op(KIND_NOP, '1, 4'd15);
      for (int i = 0; i < 12; i++)
         add_op((i % 2) ? dqi_pkg::KIND_PUSH_BACK : dqi_pkg::KIND_PUSH_FRONT,
                32'h5555_5555 ^ (i << 28), 4'(i));
      // full: both pushes dropped, last position now readable
      add_op(dqi_pkg::KIND_PUSH_FRONT, 32'haaaa_aaaa, 4'd0);
      add_op(dqi_pkg::KIND_PUSH_BACK, 32'h5555_5555, 4'd0);
      add_op(dqi_pkg::KIND_READ, '0, 4'd15);

      run_phase(0, 0, 450);
      run_phase(79, 0, 450);
      run_phase(0, 79, 450);
      run_phase(37, 37, 450);

      repeat (20) @(negedge clock);
      while (expected_rsps.size() != 0) begin
         report_mismatch("missing result", '0, '0);
         void'(expected_rsps.pop_front());
      end

      $display("%0d transactions, %0d results checked, %0d mismatches", accepted_ops,
               checked_rsps, mismatches);
      $display("reads in range %0d, out of range %0d, dropped pushes %0d, no-ops %0d",
               reads_hit, reads_missed, pushes_dropped, nops_seen);
      if (mismatches == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   initial begin
      #1_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
